>>> hdl/dlso_pkg.sv
// shared constants and types for the dual lfo with sync delay and one-shot shapes
`default_nettype none
package dlso_pkg;

	// configuration register indexes (byte address is 4 times the index)
	localparam int unsigned REG_ENABLES   = 0;
	localparam int unsigned REG_SYNC_MODE = 1;
	localparam int unsigned REG_PM_STEP   = 2;
	localparam int unsigned REG_AM_STEP   = 3;
	localparam int unsigned REG_PM_WAVE   = 4;
	localparam int unsigned REG_AM_WAVE   = 5;
	localparam int unsigned REG_SMOOTH    = 6;
	localparam int unsigned REG_DELAY     = 7;

	localparam int unsigned ADDR_BITS = 5;
	localparam int unsigned STEP_BITS = 24;
	localparam int unsigned DELAY_BITS = 24;

	typedef logic [2:0] wave_t;

	// wave codes, codes above the last one behave as the last one
	localparam wave_t WAVE_SAW      = 3'd0;
	localparam wave_t WAVE_SQUARE   = 3'd1;
	localparam wave_t WAVE_TRIANGLE = 3'd2;
	localparam wave_t WAVE_NOISE    = 3'd3;
	localparam wave_t WAVE_SHOT_A   = 3'd4;
	localparam wave_t WAVE_SHOT_B   = 3'd5;

	typedef logic [1:0] sync_t;
	localparam sync_t SYNC_FREE  = 2'd0;
	localparam sync_t SYNC_RESET = 2'd1;
	localparam sync_t SYNC_DELAY = 2'd2;

	// input kinds carried on tuser
	localparam logic FUNC_TICK = 1'b0;
	localparam logic FUNC_NOTE = 1'b1;

endpackage
`default_nettype wire

>>> hdl/dual_lfo_sync_delay_oneshot.sv
// dual phase-accumulator lfo (pitch and amplitude) with sync delay, one-shots and am smoother
//
// Input stream: s_tuser selects the kind (0 sample tick, 1 note-on), s_tdata carries
// the signed Q1.15 noise sample that is latched whenever a phase wraps.
// Output stream: one transfer per tick, none per note-on. m_tdata holds pm_value
// (signed Q1.15) in bits 15:0 and the smoothed am_value (unsigned Q0.16) in bits 31:16.
// Registers sit on an APB port at byte address 4*i; pready is always high and writes
// are meant to happen only while no item is in flight.
// An accepted item is held in the input stage; the tick's phase update, wave
// shaping and smoother step (one 17x17 multiply) then run in a single pass into the
// output register, which drives m_tvalid and m_tdata.
// One item is accepted every cycle as long as the output register is empty or drained
// in the same cycle; a note-on never waits for the output side.
// When m_tready is low the result holds and the input stage fills, then s_tready drops.
// Reset clears phases, countdown, wrap flags, held noise and the smoother, sets all
// registers to zero except smooth_rate, which resets to 65535.
`default_nettype none
module dual_lfo_sync_delay_oneshot #(
	parameter int unsigned PHASE_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // noise_sample
	input  wire logic [0:0]  s_tuser,  // func
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // pm_value, am_value
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [dlso_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import dlso_pkg::*;

	localparam int unsigned PB = PHASE_BITS;
	localparam logic [PB-1:0] PH_QTR = PB'(1) << (PB - 2);
	localparam logic [PB-1:0] PH_HALF = PB'(1) << (PB - 1);

	// configuration registers
	logic [1:0]            enables_q;
	sync_t                 sync_mode_q;
	logic [STEP_BITS-1:0]  pm_step_q;
	logic [STEP_BITS-1:0]  am_step_q;
	wave_t                 pm_wave_q;
	wave_t                 am_wave_q;
	logic [15:0]           smooth_rate_q;
	logic [DELAY_BITS-1:0] delay_ticks_q;

	// lfo state
	logic [PB-1:0]         pm_phase_q;
	logic [PB-1:0]         am_phase_q;
	logic [DELAY_BITS-1:0] delay_count_q;
	logic                  pm_wrapped_q;
	logic                  am_wrapped_q;
	logic signed [15:0]    noise_held_q;
	logic [15:0]           am_smoothed_q;

	// input stage and output register
	logic                  vld_s1;
	logic                  func_s1;
	logic signed [15:0]    noise_s1;
	logic                  vld_s2;
	logic signed [15:0]    pm_val_s2;
	logic [15:0]           am_val_s2;

	logic cfg_wr;
	logic out_free;
	logic fire_s1;
	logic tick_s1;
	logic note_s1;

	// x * 2^fb / 2^PB, truncated, for fb of 16 and 17
	function automatic logic [17:0] scale16(input logic [PB-1:0] x);
		logic [PB+15:0] w;
		w = {x, 16'b0} >> PB;
		return w[17:0];
	endfunction

	function automatic logic [17:0] scale17(input logic [PB-1:0] x);
		logic [PB+16:0] w;
		w = {x, 17'b0} >> PB;
		return w[17:0];
	endfunction

	function automatic wave_t wave_limit(input wave_t w);
		return (w > WAVE_SHOT_B) ? WAVE_SHOT_B : w;
	endfunction

	// ---------------------------------------------------------------- config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enables_q     <= '0;
			sync_mode_q   <= SYNC_FREE;
			pm_step_q     <= '0;
			am_step_q     <= '0;
			pm_wave_q     <= WAVE_SAW;
			am_wave_q     <= WAVE_SAW;
			smooth_rate_q <= 16'hFFFF;
			delay_ticks_q <= '0;
		end else if (cfg_wr) begin
			case (32'(paddr[ADDR_BITS-1:2]))
				REG_ENABLES:   enables_q     <= pwdata[1:0];
				REG_SYNC_MODE: sync_mode_q   <= pwdata[1:0];
				REG_PM_STEP:   pm_step_q     <= pwdata[STEP_BITS-1:0];
				REG_AM_STEP:   am_step_q     <= pwdata[STEP_BITS-1:0];
				REG_PM_WAVE:   pm_wave_q     <= pwdata[2:0];
				REG_AM_WAVE:   am_wave_q     <= pwdata[2:0];
				REG_SMOOTH:    smooth_rate_q <= pwdata[15:0];
				REG_DELAY:     delay_ticks_q <= pwdata[DELAY_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (32'(paddr[ADDR_BITS-1:2]))
			REG_ENABLES:   prdata = 32'(enables_q);
			REG_SYNC_MODE: prdata = 32'(sync_mode_q);
			REG_PM_STEP:   prdata = 32'(pm_step_q);
			REG_AM_STEP:   prdata = 32'(am_step_q);
			REG_PM_WAVE:   prdata = 32'(pm_wave_q);
			REG_AM_WAVE:   prdata = 32'(am_wave_q);
			REG_SMOOTH:    prdata = 32'(smooth_rate_q);
			REG_DELAY:     prdata = 32'(delay_ticks_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- handshakes
	assign out_free = !vld_s2 || m_tready;
	assign fire_s1  = vld_s1 && ((func_s1 == FUNC_NOTE) || out_free);
	assign tick_s1  = fire_s1 && (func_s1 == FUNC_TICK);
	assign note_s1  = fire_s1 && (func_s1 == FUNC_NOTE);
	assign s_tready = !vld_s1 || fire_s1;
	assign m_tvalid = vld_s2;
	assign m_tdata  = {am_val_s2, pm_val_s2};

	// ---------------------------------------------------------------- tick logic
	wave_t                 pm_sel, am_sel;
	logic                  pm_shot, am_shot;
	logic                  run_en;
	logic [DELAY_BITS-1:0] dc_dec;
	logic                  advance;
	logic [PB:0]           pm_sum, am_sum;
	logic [PB-1:0]         pm_step_w, am_step_w;
	logic [PB-1:0]         pm_ph, am_ph;
	logic                  pm_wrap, am_wrap;
	logic signed [15:0]    noise_nx;
	logic                  pm_wr_nx, am_wr_nx;
	logic signed [18:0]    pm_raw, am_raw;
	logic signed [15:0]    pm_tgt;
	logic [15:0]           am_tgt;
	logic signed [16:0]    sm_diff;
	logic signed [33:0]    sm_prod;
	logic signed [34:0]    sm_round;
	logic signed [18:0]    sm_inc;
	logic signed [19:0]    sm_sum;
	logic [15:0]           sm_nx;

	always_comb begin
		pm_sel  = wave_limit(pm_wave_q);
		am_sel  = wave_limit(am_wave_q);
		pm_shot = pm_sel >= WAVE_SHOT_A;
		am_shot = am_sel >= WAVE_SHOT_A;
		run_en  = enables_q != 2'b00;
		dc_dec  = (delay_count_q != '0) ? delay_count_q - 1'b1 : delay_count_q;
		advance = run_en && (dc_dec == '0);

		// step register may be narrower or wider than the phase
		pm_step_w = PB'(pm_step_q);
		am_step_w = PB'(am_step_q);
		pm_sum  = {1'b0, pm_phase_q} + {1'b0, pm_step_w};
		am_sum  = {1'b0, am_phase_q} + {1'b0, am_step_w};
		pm_wrap = pm_sum[PB];
		am_wrap = am_sum[PB];
		pm_ph   = pm_sum[PB-1:0];
		am_ph   = am_sum[PB-1:0];
		noise_nx = (pm_wrap || am_wrap) ? noise_s1 : noise_held_q;
		pm_wr_nx = pm_wrapped_q || pm_wrap;
		am_wr_nx = am_wrapped_q || am_wrap;

		// pitch shape
		case (pm_sel)
			WAVE_SAW:
				pm_raw = $signed({1'b0, scale16(pm_ph)})
					- (pm_ph[PB-1] ? 19'sd65536 : 19'sd32768);
			WAVE_SQUARE:
				pm_raw = pm_ph[PB-1] ? 19'sd0 : 19'sd32768;
			WAVE_TRIANGLE: begin
				if (pm_ph[PB-1:PB-2] == 2'b00)
					pm_raw = $signed({1'b0, scale17(pm_ph)});
				else if (pm_ph[PB-1:PB-2] != 2'b11)
					pm_raw = 19'sd32768 - $signed({1'b0, scale17(pm_ph - PH_QTR)});
				else
					pm_raw = $signed({1'b0, scale17(pm_ph - PH_QTR - PH_HALF)})
						- 19'sd32768;
			end
			WAVE_NOISE:
				pm_raw = 19'(noise_nx);
			WAVE_SHOT_A:
				pm_raw = pm_ph[PB-1] ? 19'sd0
					: 19'sd32768 - $signed({1'b0, scale16(pm_ph)});
			default: begin
				if (pm_ph[PB-1:PB-2] == 2'b00)
					pm_raw = $signed({1'b0, scale17(pm_ph)});
				else if (pm_ph[PB-1:PB-2] == 2'b01)
					pm_raw = 19'sd32768 - $signed({1'b0, scale17(pm_ph - PH_QTR)});
				else
					pm_raw = 19'sd0;
			end
		endcase

		// amplitude shape, on its own phase
		case (am_sel)
			WAVE_SAW:
				am_raw = $signed({1'b0, scale16(am_ph)});
			WAVE_SQUARE:
				am_raw = am_ph[PB-1] ? 19'sd0 : 19'sd65536;
			WAVE_TRIANGLE:
				am_raw = am_ph[PB-1]
					? 19'sd65536 - $signed({1'b0, scale17(am_ph - PH_HALF)})
					: $signed({1'b0, scale17(am_ph)});
			WAVE_NOISE:
				am_raw = 19'(noise_nx) + 19'sd32768;
			WAVE_SHOT_A:
				am_raw = am_ph[PB-1] ? 19'sd0
					: 19'sd65536 - $signed({1'b0, scale16(am_ph)});
			default:
				am_raw = am_ph[PB-1] ? 19'sd0 : $signed({1'b0, scale17(am_ph)});
		endcase

		if (!advance || (pm_shot && pm_wr_nx))
			pm_tgt = '0;
		else if (pm_raw > 19'sd32767)
			pm_tgt = 16'sd32767;
		else if (pm_raw < -19'sd32768)
			pm_tgt = -16'sd32768;
		else
			pm_tgt = pm_raw[15:0];

		if (!advance || (am_shot && am_wr_nx))
			am_tgt = '0;
		else if (am_raw > 19'sd65535)
			am_tgt = 16'hFFFF;
		else if (am_raw < 19'sd0)
			am_tgt = '0;
		else
			am_tgt = am_raw[15:0];

		// one-pole smoother, rounding half up is an arithmetic shift of prod + 0.5
		sm_diff  = $signed({1'b0, am_tgt}) - $signed({1'b0, am_smoothed_q});
		sm_prod  = sm_diff * $signed({1'b0, smooth_rate_q});
		sm_round = 35'(sm_prod) + 35'sd32768;
		sm_inc   = 19'(sm_round >>> 16);
		sm_sum   = $signed({4'b0, am_smoothed_q}) + 20'(sm_inc);
		if (sm_sum < 20'sd0)
			sm_nx = '0;
		else if (sm_sum > 20'sd65535)
			sm_nx = 16'hFFFF;
		else
			sm_nx = sm_sum[15:0];
	end

	// ---------------------------------------------------------------- state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_phase_q    <= '0;
			am_phase_q    <= '0;
			delay_count_q <= '0;
			pm_wrapped_q  <= 1'b0;
			am_wrapped_q  <= 1'b0;
			noise_held_q  <= '0;
			am_smoothed_q <= '0;
		end else if (note_s1) begin
			if (sync_mode_q != SYNC_FREE || pm_shot || am_shot) begin
				pm_phase_q <= '0;
				am_phase_q <= '0;
			end
			delay_count_q <= (sync_mode_q >= SYNC_DELAY) ? delay_ticks_q : '0;
			pm_wrapped_q  <= 1'b0;
			am_wrapped_q  <= 1'b0;
		end else if (tick_s1) begin
			am_smoothed_q <= sm_nx;
			if (run_en)
				delay_count_q <= dc_dec;
			if (advance) begin
				pm_phase_q   <= pm_ph;
				am_phase_q   <= am_ph;
				pm_wrapped_q <= pm_wr_nx;
				am_wrapped_q <= am_wr_nx;
				noise_held_q <= noise_nx;
			end
		end
	end

	// ---------------------------------------------------------------- pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				vld_s1 <= 1'b1;
			else if (fire_s1)
				vld_s1 <= 1'b0;
			if (tick_s1)
				vld_s2 <= 1'b1;
			else if (m_tready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1  <= s_tuser[0];
			noise_s1 <= s_tdata;
		end
		if (tick_s1) begin
			pm_val_s2 <= pm_tgt;
			am_val_s2 <= sm_nx;
		end
	end

endmodule
`default_nettype wire

>>> sim/dual_lfo_sync_delay_oneshot_tb.sv
// self-checking testbench for the dual lfo with sync delay, one-shot shapes and am smoother
`default_nettype none
module dual_lfo_sync_delay_oneshot_tb;
	import dlso_pkg::*;

	localparam logic [23:0] PH_HALF = 24'h800000;
	localparam logic [23:0] PH_QTR  = 24'h400000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [15:0] am;
		logic [15:0] pm;
	} lfo_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	wire logic            s_tready;
	logic [15:0]          s_tdata = '0;  // noise_sample
	logic [0:0]           s_tuser = '0;  // func
	wire logic            m_tvalid;
	logic                 m_tready = 1'b0;
	wire logic [31:0]     m_tdata;       // pm_value, am_value
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [31:0]          pwdata = '0;
	wire logic [31:0]     prdata;
	wire logic            pready;

	// register shadow
	logic [1:0]  cfg_enables = '0;
	sync_t       cfg_sync = SYNC_FREE;
	logic [23:0] cfg_pm_step = '0;
	logic [23:0] cfg_am_step = '0;
	wave_t       cfg_pm_wave = WAVE_SAW;
	wave_t       cfg_am_wave = WAVE_SAW;
	logic [15:0] cfg_smooth = 16'hFFFF;
	logic [23:0] cfg_delay = '0;

	// lfo state
	logic [23:0]        pm_phase = '0;
	logic [23:0]        am_phase = '0;
	logic [23:0]        delay_count = '0;
	logic               pm_wrapped = 1'b0;
	logic               am_wrapped = 1'b0;
	logic signed [15:0] noise_held = '0;
	logic [15:0]        am_smoothed = '0;

	lfo_out_t lfo_values_q[$];
	lfo_out_t want;
	int errors = 0;
	int n_ticks = 0;
	int n_notes = 0;
	int n_checked = 0;
	bit src_idle_on = 1'b1;
	bit snk_stall_on = 1'b1;

	dual_lfo_sync_delay_oneshot u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= !(snk_stall_on && $urandom_range(99) < 6);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_checked++;
			if (lfo_values_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result pm=%h am=%h", $time, m_tdata[15:0],
					m_tdata[31:16]);
			end else begin
				want = lfo_values_q.pop_front();
				if (m_tdata[15:0] !== want.pm) begin
					errors++;
					$display("%0t: pm_value expected %h actual %h", $time, want.pm,
						m_tdata[15:0]);
				end
				if (m_tdata[31:16] !== want.am) begin
					errors++;
					$display("%0t: am_value expected %h actual %h", $time, want.am,
						m_tdata[31:16]);
				end
			end
		end
	end

	function automatic wave_t eff_wave(input wave_t w);
		return (w > WAVE_SHOT_B) ? WAVE_SHOT_B : w;
	endfunction

	function automatic bit is_oneshot(input wave_t w);
		return eff_wave(w) >= WAVE_SHOT_A;
	endfunction

	function automatic int clamp(input int v, input int lo, input int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int pitch_shape(input logic [23:0] p);
		int pv;
		int v;
		pv = int'(p);
		case (eff_wave(cfg_pm_wave))
			WAVE_SAW: v = (pv >> 8) - ((p < PH_HALF) ? 32768 : 65536);
			WAVE_SQUARE: v = (p < PH_HALF) ? 32768 : 0;
			WAVE_TRIANGLE: begin
				if (p < PH_QTR) v = pv >> 7;
				else if (p < 3 * PH_QTR) v = 32768 - ((pv - int'(PH_QTR)) >> 7);
				else v = -32768 + ((pv - 3 * int'(PH_QTR)) >> 7);
			end
			WAVE_NOISE: v = int'(noise_held);
			WAVE_SHOT_A: v = (p < PH_HALF) ? 32768 - (pv >> 8) : 0;
			default: begin
				if (p < PH_QTR) v = pv >> 7;
				else if (p < PH_HALF) v = 32768 - ((pv - int'(PH_QTR)) >> 7);
				else v = 0;
			end
		endcase
		return clamp(v, -32768, 32767);
	endfunction

	function automatic int amp_shape(input logic [23:0] p);
		int pv;
		int v;
		pv = int'(p);
		case (eff_wave(cfg_am_wave))
			WAVE_SAW: v = pv >> 8;
			WAVE_SQUARE: v = (p < PH_HALF) ? 65536 : 0;
			WAVE_TRIANGLE: v = (p < PH_HALF) ? (pv >> 7) : 65536 - ((pv - int'(PH_HALF)) >> 7);
			WAVE_NOISE: v = int'(noise_held) + 32768;
			WAVE_SHOT_A: v = (p < PH_HALF) ? 65536 - (pv >> 8) : 0;
			default: v = (p < PH_HALF) ? (pv >> 7) : 0;
		endcase
		return clamp(v, 0, 65535);
	endfunction

	// advance the lfo by one accepted item and queue the tick's result
	task automatic step_lfo(input logic func, input logic [15:0] noise);
		int pmv;
		int amv;
		longint prod;
		logic [24:0] pm_sum;
		logic [24:0] am_sum;
		lfo_out_t r;
		pmv = 0;
		amv = 0;
		if (func == FUNC_NOTE) begin
			n_notes++;
			if (cfg_sync != SYNC_FREE || is_oneshot(cfg_pm_wave) || is_oneshot(cfg_am_wave)) begin
				pm_phase = '0;
				am_phase = '0;
			end
			delay_count = (cfg_sync >= SYNC_DELAY) ? cfg_delay : '0;
			pm_wrapped = 1'b0;
			am_wrapped = 1'b0;
			return;
		end
		n_ticks++;
		if (cfg_enables != 2'd0) begin
			if (delay_count != 0) delay_count--;
			if (delay_count == 0) begin
				pm_sum = {1'b0, pm_phase} + {1'b0, cfg_pm_step};
				am_sum = {1'b0, am_phase} + {1'b0, cfg_am_step};
				if (pm_sum[24] || am_sum[24]) noise_held = noise;
				pm_phase = pm_sum[23:0];
				am_phase = am_sum[23:0];
				if (pm_sum[24]) pm_wrapped = 1'b1;
				if (am_sum[24]) am_wrapped = 1'b1;
				pmv = pitch_shape(pm_phase);
				amv = amp_shape(am_phase);
				if (is_oneshot(cfg_pm_wave) && pm_wrapped) pmv = 0;
				if (is_oneshot(cfg_am_wave) && am_wrapped) amv = 0;
			end
		end
		// one-pole smoother, round half up, floor via arithmetic shift
		prod = longint'(amv - int'(am_smoothed)) * longint'(cfg_smooth) + 64'sd32768;
		am_smoothed = 16'(clamp(int'(am_smoothed) + int'(prod >>> 16), 0, 65535));
		r.pm = 16'(pmv);
		r.am = am_smoothed;
		lfo_values_q.push_back(r);
	endtask

	task automatic write_reg(input int unsigned idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ENABLES: cfg_enables = val[1:0];
			REG_SYNC_MODE: cfg_sync = val[1:0];
			REG_PM_STEP: cfg_pm_step = val[23:0];
			REG_AM_STEP: cfg_am_step = val[23:0];
			REG_PM_WAVE: cfg_pm_wave = val[2:0];
			REG_AM_WAVE: cfg_am_wave = val[2:0];
			REG_SMOOTH: cfg_smooth = val[15:0];
			REG_DELAY: cfg_delay = val[23:0];
			default: ;
		endcase
	endtask

	task automatic send_item(input logic func, input logic [15:0] noise);
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= noise;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		step_lfo(func, noise);
		if (src_idle_on && $urandom_range(99) < 4) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	// stop sending and let every outstanding tick come out; note-ons leave no trace
	task automatic drain_stream;
		s_tvalid <= 1'b0;
		while (lfo_values_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_defaults;
		send_item(FUNC_TICK, 16'h7FFF);
		send_item(FUNC_TICK, 16'h8000);
		drain_stream();
	endtask

	task automatic test_wave_codes;
		write_reg(REG_ENABLES, 32'd3);
		write_reg(REG_PM_STEP, 32'h600000);
		write_reg(REG_AM_STEP, 32'hA00001);
		for (int w = 0; w < 8; w++) begin
			write_reg(REG_PM_WAVE, 32'(w));
			write_reg(REG_AM_WAVE, 32'(7 - w));
			send_item(FUNC_TICK, 16'h8000);
			send_item(FUNC_TICK, 16'h7FFF);
			drain_stream();
		end
	endtask

	// sync mode three behaves as reset plus delay
	task automatic test_sync_delay;
		write_reg(REG_SYNC_MODE, 32'd3);
		write_reg(REG_DELAY, 32'd2);
		write_reg(REG_PM_WAVE, 32'(WAVE_TRIANGLE));
		write_reg(REG_AM_WAVE, 32'(WAVE_SQUARE));
		send_item(FUNC_NOTE, 16'h1234);
		repeat (3) send_item(FUNC_TICK, 16'($urandom));
		drain_stream();
	endtask

	task automatic test_oneshot_free_run;
		write_reg(REG_SYNC_MODE, 32'(SYNC_FREE));
		write_reg(REG_PM_WAVE, 32'(WAVE_SHOT_A));
		write_reg(REG_AM_WAVE, 32'(WAVE_SHOT_B));
		write_reg(REG_PM_STEP, 32'h800000);
		write_reg(REG_AM_STEP, 32'h400000);
		send_item(FUNC_NOTE, 16'h0000);
		repeat (3) send_item(FUNC_TICK, 16'hFFFF);
		drain_stream();
	endtask

	task automatic test_both_disabled;
		write_reg(REG_ENABLES, 32'd0);
		write_reg(REG_SMOOTH, 32'h8000);
		send_item(FUNC_TICK, 16'h5555);
		send_item(FUNC_TICK, 16'hAAAA);
		drain_stream();
	endtask

	function automatic logic [23:0] pick_step;
		case ($urandom_range(9))
			0: return 24'h000000;
			1: return 24'hFFFFFF;
			2, 3: return 24'($urandom_range(1, 4096));
			4: return 24'($urandom_range(4096, 24'h100000));
			default: return 24'($urandom);
		endcase
	endfunction

	// style 0 random, 1 upper extremes, 2 lower extremes
	task automatic program_config(input int style);
		logic [23:0] dly;
		case ($urandom_range(9))
			0: dly = 24'($urandom);
			1, 2: dly = 24'($urandom_range(0, 255));
			default: dly = 24'($urandom_range(0, 40));
		endcase
		case (style)
			1: begin
				write_reg(REG_ENABLES, 32'd3);
				write_reg(REG_SYNC_MODE, 32'd3);
				write_reg(REG_PM_STEP, 32'hFFFFFF);
				write_reg(REG_AM_STEP, 32'hFFFFFF);
				write_reg(REG_PM_WAVE, 32'd7);
				write_reg(REG_AM_WAVE, 32'd7);
				write_reg(REG_SMOOTH, 32'hFFFF);
				write_reg(REG_DELAY, 32'hFFFFFF);
			end
			2: begin
				write_reg(REG_ENABLES, 32'd1);
				write_reg(REG_SYNC_MODE, 32'(SYNC_FREE));
				write_reg(REG_PM_STEP, 32'd1);
				write_reg(REG_AM_STEP, 32'd0);
				write_reg(REG_PM_WAVE, 32'(WAVE_SAW));
				write_reg(REG_AM_WAVE, 32'(WAVE_NOISE));
				write_reg(REG_SMOOTH, 32'd0);
				write_reg(REG_DELAY, 32'd0);
			end
			default: begin
				write_reg(REG_ENABLES, ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(1, 3)));
				write_reg(REG_SYNC_MODE, 32'($urandom_range(3)));
				write_reg(REG_PM_STEP, 32'(pick_step()));
				write_reg(REG_AM_STEP, 32'(pick_step()));
				write_reg(REG_PM_WAVE, 32'($urandom_range(7)));
				write_reg(REG_AM_WAVE, 32'($urandom_range(7)));
				case ($urandom_range(5))
					0: write_reg(REG_SMOOTH, 32'd0);
					1: write_reg(REG_SMOOTH, 32'hFFFF);
					default: write_reg(REG_SMOOTH, 32'($urandom_range(0, 65535)));
				endcase
				write_reg(REG_DELAY, 32'(dly));
			end
		endcase
	endtask

	task automatic test_random_phases;
		int n;
		for (int ph = 0; ph < 11; ph++) begin
			// one phase with no idling on either side
			src_idle_on = (ph != 5);
			snk_stall_on = (ph != 5);
			program_config((ph == 0) ? 1 : ((ph == 1) ? 2 : 0));
			n = 95;
			for (int i = 0; i < n; i++) begin
				if (i == n / 2 && ph % 3 == 0) drain_stream();
				send_item(($urandom_range(99) < 5) ? FUNC_NOTE : FUNC_TICK, 16'($urandom));
			end
			drain_stream();
		end
		src_idle_on = 1'b1;
		snk_stall_on = 1'b1;
	endtask

	initial begin
		#5_000_000;
		$display("dual_lfo_sync_delay_oneshot_tb: done, errors");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_wave_codes();
		test_sync_delay();
		test_oneshot_free_run();
		test_both_disabled();
		test_random_phases();
		drain_stream();
		repeat (10) @(posedge clk);
		$display("covered %0d ticks and %0d note-ons over all wave codes, sync modes,", n_ticks,
			n_notes);
		$display("delay and one-shot cases; %0d results compared, %0d mismatches", n_checked,
			errors);
		if (errors == 0) begin
			$display("dual_lfo_sync_delay_oneshot_tb: done, clean");
		end else begin
			$display("dual_lfo_sync_delay_oneshot_tb: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
hdl/dlso_pkg.sv
hdl/dual_lfo_sync_delay_oneshot.sv
sim/dual_lfo_sync_delay_oneshot_tb.sv
